### sv/blti_pkg.sv
package blti_pkg;

    localparam int RATE_W  = 24;
    localparam int BRK_W   = 16;
    localparam int BRK_N   = 8;
    localparam int SEG_W   = 3;
    localparam int PH_W    = 18;
    localparam int PROD_W  = 44;
    localparam int ROWR_W  = 34;
    localparam int DR_W    = 35;
    localparam int DZ_W    = 17;
    localparam int BIG_W   = 52;
    localparam int NUM_W   = 56;
    localparam int DEN_W   = 18;
    localparam int SUM_W   = 58;
    localparam int EXP_W   = 10;
    localparam int MANT_W  = 16;

    localparam logic [15:0] TEMP_FLOOR = 16'd16384;
    localparam logic [29:0] LOG2_TEN_Q28 = 30'd891723283;
    localparam logic [29:0] LN_TWO_Q30 = 30'd744261118;
    localparam logic [30:0] ONE_Q30 = 31'd1073741824;
    localparam logic [3:0] SERIES_TERMS = 4'd12;

    localparam logic signed [RATE_W-1:0] RATE_MAX = 24'sh7FFFFF;
    localparam logic signed [RATE_W-1:0] RATE_MIN = -24'sh800000;

    localparam logic signed [BRK_W-1:0] BREAK_RESET [BRK_N] = '{
        -16'sd27439, -16'sd19247, -16'sd15151, -16'sd13103,
        -16'sd11055, -16'sd9007, -16'sd6959, -16'sd4911
    };

    typedef enum logic [4:0] {
        ST_IDLE, ST_SCAN, ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_RD4,
        ST_MUL0, ST_MUL1, ST_ROW, ST_MZ, ST_NUM, ST_DIV, ST_SAT,
        ST_EXP, ST_DONE
    } seq_state_t;

    typedef enum logic [2:0] {
        EX_IDLE, EX_LOG, EX_ARG, EX_MUL, EX_REC, EX_FIX, EX_RND
    } exp_state_t;

    // floor(2^32 / n) for the series divisors
    function automatic logic [32:0] recip(input logic [3:0] n);
        logic [32:0] r;
        unique case (n)
            4'd1:    r = 33'd4294967296;
            4'd2:    r = 33'd2147483648;
            4'd3:    r = 33'd1431655765;
            4'd4:    r = 33'd1073741824;
            4'd5:    r = 33'd858993459;
            4'd6:    r = 33'd715827882;
            4'd7:    r = 33'd613566756;
            4'd8:    r = 33'd536870912;
            4'd9:    r = 33'd477218588;
            4'd10:   r = 33'd429496729;
            4'd11:   r = 33'd390451572;
            4'd12:   r = 33'd357913941;
            default: r = 33'd4294967296;
        endcase
        return r;
    endfunction

endpackage

### sv/blti_table.sv
module blti_table import blti_pkg::*; #(
    parameter int DEPTH  = 728,
    parameter int ADDR_W = 10
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [ADDR_W-1:0]        wr_addr,
    input  logic signed [RATE_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]        rd_addr,
    output logic signed [RATE_W-1:0] rd_data
);

    logic signed [RATE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

### sv/blti_divider.sv
module blti_divider import blti_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             done,
    output logic [NUM_W-1:0] quotient,
    output logic             rem_nonzero
);

    localparam int STEPS = NUM_W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [DEN_W:0]   rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;

    // two restoring steps per cycle
    always_comb
    begin
        logic [DEN_W:0]   r;
        logic [NUM_W-1:0] q;
        r = rem_reg;
        q = quo_reg;
        for (int i = 0; i < 2; i++)
        begin
            r = {r[DEN_W-1:0], q[NUM_W-1]};
            q = {q[NUM_W-2:0], 1'b0};
            if (r >= {1'b0, den_reg})
            begin
                r = r - {1'b0, den_reg};
                q[0] = 1'b1;
            end
        end
        rem_next = r;
        quo_next = q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done        = done_reg;
    assign quotient    = quo_reg;
    assign rem_nonzero = (rem_reg != '0);

endmodule

### sv/blti_exp2.sv
module blti_exp2 import blti_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [RATE_W-1:0] rate,
    output logic                     done,
    output logic [EXP_W-1:0]         exponent,
    output logic [MANT_W-1:0]        mantissa
);

    exp_state_t state_reg, state_next;

    logic signed [RATE_W-1:0] rate_reg;
    logic signed [53:0]       y_reg;
    logic [29:0]              a_reg;
    logic [30:0]              term_reg;
    logic [31:0]              sum_reg;
    logic [29:0]              p_reg;
    logic [62:0]              qm_reg;
    logic [3:0]               n_reg;
    logic [EXP_W-1:0]         e_reg;
    logic [MANT_W-1:0]        mant_reg;
    logic                     done_int;

    logic [45:0] a_full;
    logic [60:0] tp_full;
    logic [29:0] q0, q_fix;
    logic [33:0] back;
    logic [16:0] mant_rnd;

    assign a_full  = 46'(y_reg[43:28]) * 46'(LN_TWO_Q30);
    assign tp_full = 61'(term_reg) * 61'(a_reg);
    assign q0      = qm_reg[61:32];
    assign back    = 34'(q0) * 34'(n_reg);
    assign q_fix   = (34'(p_reg) - back >= 34'(n_reg)) ? q0 + 30'd1 : q0;
    assign mant_rnd = 17'((33'(sum_reg) + 33'd16384) >> 15);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            EX_IDLE: if (start) state_next = EX_LOG;
            EX_LOG:  state_next = EX_ARG;
            EX_ARG:  state_next = EX_MUL;
            EX_MUL:  state_next = EX_REC;
            EX_REC:  state_next = EX_FIX;
            EX_FIX:  state_next = (n_reg == SERIES_TERMS) ? EX_RND : EX_MUL;
            EX_RND:  state_next = EX_IDLE;
            default: state_next = EX_IDLE;
        endcase
    end

    always_comb
    begin
        done_int = (state_reg == EX_RND);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= EX_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            EX_IDLE:
            begin
                rate_reg <= rate;
            end
            EX_LOG:
            begin
                y_reg <= 54'(rate_reg) * $signed({1'b0, LOG2_TEN_Q28});
            end
            EX_ARG:
            begin
                a_reg    <= a_full[45:16];
                e_reg    <= y_reg[53:44];
                term_reg <= ONE_Q30;
                sum_reg  <= 32'(ONE_Q30);
                n_reg    <= 4'd1;
            end
            EX_MUL:
            begin
                p_reg <= tp_full[59:30];
            end
            EX_REC:
            begin
                qm_reg <= 63'(p_reg) * 63'(recip(n_reg));
            end
            EX_FIX:
            begin
                term_reg <= 31'(q_fix);
                sum_reg  <= sum_reg + 32'(q_fix);
                n_reg    <= n_reg + 4'd1;
            end
            EX_RND:
            begin
                // a mantissa that rounds up to two wraps to one
                if (mant_rnd[16])
                begin
                    mant_reg <= 16'h8000;
                    e_reg    <= e_reg + 1'b1;
                end
                else
                begin
                    mant_reg <= mant_rnd[15:0];
                end
            end
            default:
            begin
                rate_reg <= rate_reg;
            end
        endcase
    end

    assign done     = done_int;
    assign exponent = e_reg;
    assign mantissa = mant_reg;

endmodule

### sv/bilinear_log_table_interpolator.sv
// Bilinear log-rate table interpolator.
// Input channel (in_valid/in_stall): operation 0 writes entry_value into the
// table at metal_row/temp_column (out-of-range writes are dropped); operation
// 1 queries with log_temp and log_metal and yields one output beat.
// Output channel (out_valid/out_stall): log_rate, rate_exponent,
// rate_mantissa and saturated, held in an output register.
// A query passes from its input beat to its output beat through breakpoint
// scan, the four table reads on the one read port, row and blend
// arithmetic, the two-bit-per-cycle divider, saturation, the power series
// unit (twelve terms) and the load of the output register. A segment of
// zero or negative width skips the divider.
// in_stall is high while a query is in flight, so a query is taken only
// after the previous one has loaded the output register; the next item is
// taken while the previous result still waits in the output register.
// When out_stall holds the output register, a finished query waits for it.
// Breakpoint registers are to be written by the user through cfg_write/
// cfg_index/cfg_data only while idle; the block itself does not enforce it.
// Reset restores the default breakpoints and clears all control state;
// table contents are undefined until written.
module bilinear_log_table_interpolator import blti_pkg::*; #(
    parameter int TEMP_POINTS  = 91,
    parameter int METAL_POINTS = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      operation,
    input  logic [2:0]                metal_row,
    input  logic [6:0]                temp_column,
    input  logic signed [RATE_W-1:0]  entry_value,
    input  logic [15:0]               log_temp,
    input  logic signed [BRK_W-1:0]   log_metal,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [RATE_W-1:0]  log_rate,
    output logic signed [EXP_W-1:0]   rate_exponent,
    output logic [MANT_W-1:0]         rate_mantissa,
    output logic                      saturated,
    input  logic                      cfg_write,
    input  logic [SEG_W-1:0]          cfg_index,
    input  logic signed [BRK_W-1:0]   cfg_data
);

    localparam int DEPTH  = METAL_POINTS * TEMP_POINTS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [7:0] CELL_MAX = 8'(TEMP_POINTS - 2);

    seq_state_t state_reg, state_next;

    logic signed [BRK_W-1:0] brk_reg [BRK_N];

    logic [7:0]               cell_reg;
    logic [PH_W-1:0]          ph_reg;
    logic signed [BRK_W-1:0]  z_reg, blo_reg, bhi_reg;
    logic [SEG_W-1:0]         seg_reg;
    logic signed [RATE_W-1:0] r0_reg, r1_reg, r2_reg, r3_reg;
    logic signed [PROD_W-1:0] pa_reg, pb_reg;
    logic signed [ROWR_W-1:0] ra_reg, rb_reg;
    logic signed [BIG_W-1:0]  big_reg;
    logic                     neg_reg;
    logic signed [SUM_W-1:0]  rsum_reg;
    logic signed [RATE_W-1:0] rate_reg;
    logic                     sat_reg;

    logic                     out_valid_reg;
    logic signed [RATE_W-1:0] log_rate_reg;
    logic [EXP_W-1:0]         exp_out_reg;
    logic [MANT_W-1:0]        mant_out_reg;
    logic                     sat_out_reg;

    logic in_take, wr_take, q_take, out_load;

    // query front end
    logic [15:0]              t_clamp;
    logic [PH_W-1:0]          t5;
    logic [7:0]               cell_raw, cell_sel;
    logic signed [BRK_W-1:0]  z_lo, z_cl, brk_next;
    logic                     scan_go;

    assign t_clamp  = (log_temp > TEMP_FLOOR) ? log_temp - TEMP_FLOOR : 16'd0;
    assign t5       = PH_W'({t_clamp, 2'b00}) + PH_W'(t_clamp);
    assign cell_raw = t5[17:10];
    assign cell_sel = (cell_raw > CELL_MAX) ? CELL_MAX : cell_raw;
    assign z_lo     = (log_metal < brk_reg[0]) ? brk_reg[0] : log_metal;
    assign z_cl     = (z_lo > brk_reg[METAL_POINTS-1]) ? brk_reg[METAL_POINTS-1] : z_lo;
    assign brk_next = brk_reg[seg_reg + 3'd1];
    assign scan_go  = (int'(seg_reg) < METAL_POINTS - 2) && (z_reg > brk_next);

    // table access
    logic                     mem_we;
    logic [ADDR_W-1:0]        wr_addr, rd_addr;
    logic signed [RATE_W-1:0] rd_data;
    logic                     rd_row_hi, rd_col_hi;
    logic [SEG_W-1:0]         rd_row;
    logic [8:0]               rd_col;

    assign wr_addr = ADDR_W'(int'(metal_row) * TEMP_POINTS + int'(temp_column));
    assign mem_we  = wr_take && (int'(metal_row) < METAL_POINTS)
                     && (int'(temp_column) < TEMP_POINTS);
    assign rd_row  = rd_row_hi ? seg_reg + 3'd1 : seg_reg;
    assign rd_col  = rd_col_hi ? {1'b0, cell_reg} + 9'd1 : {1'b0, cell_reg};
    assign rd_addr = ADDR_W'(int'(rd_row) * TEMP_POINTS + int'(rd_col));

    blti_table #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (wr_addr),
        .wr_data (entry_value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // row interpolation and metallicity blend
    logic signed [PROD_W-1:0] pa_n, pb_n, pa_rnd, pb_rnd;
    logic signed [ROWR_W-1:0] ra_n, rb_n;
    logic signed [DR_W-1:0]   dr;
    logic signed [DZ_W-1:0]   dz, w;
    logic signed [NUM_W-1:0]  num;
    logic [NUM_W-1:0]         num_mag;
    logic [DEN_W-1:0]         den;
    logic                     w_pos;

    assign pa_n   = (PROD_W'(r1_reg) - PROD_W'(r0_reg)) * $signed({1'b0, ph_reg});
    assign pb_n   = (PROD_W'(r3_reg) - PROD_W'(r2_reg)) * $signed({1'b0, ph_reg});
    assign pa_rnd = pa_reg + 44'sd512;
    assign pb_rnd = pb_reg + 44'sd512;
    assign ra_n   = ROWR_W'(pa_rnd >>> 10) + ROWR_W'(r0_reg);
    assign rb_n   = ROWR_W'(pb_rnd >>> 10) + ROWR_W'(r2_reg);
    assign dr     = DR_W'(rb_reg) - DR_W'(ra_reg);
    assign dz     = DZ_W'(z_reg) - DZ_W'(blo_reg);
    assign w      = DZ_W'(bhi_reg) - DZ_W'(blo_reg);
    assign w_pos  = (w > 17'sd0);
    assign num    = (NUM_W'(big_reg) <<< 1) + NUM_W'(w);
    assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign den    = {w, 1'b0};

    logic                    div_start, div_done, div_nz;
    logic [NUM_W-1:0]        div_q;
    logic signed [SUM_W-1:0] q_signed;

    blti_divider u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (div_start),
        .dividend    (num_mag),
        .divisor     (den),
        .done        (div_done),
        .quotient    (div_q),
        .rem_nonzero (div_nz)
    );

    // floor division: round the magnitude up for a negative numerator
    assign q_signed = neg_reg ? -(SUM_W'(div_q) + SUM_W'(div_nz)) : SUM_W'(div_q);

    logic signed [RATE_W-1:0] rate_sat;
    logic                     sat_flag;

    always_comb
    begin
        if (rsum_reg > SUM_W'(RATE_MAX))
        begin
            rate_sat = RATE_MAX;
            sat_flag = 1'b1;
        end
        else if (rsum_reg < SUM_W'(RATE_MIN))
        begin
            rate_sat = RATE_MIN;
            sat_flag = 1'b1;
        end
        else
        begin
            rate_sat = rsum_reg[RATE_W-1:0];
            sat_flag = 1'b0;
        end
    end

    logic              exp_start, exp_done;
    logic [EXP_W-1:0]  exp_e;
    logic [MANT_W-1:0] exp_m;

    blti_exp2 u_exp (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (exp_start),
        .rate     (rate_sat),
        .done     (exp_done),
        .exponent (exp_e),
        .mantissa (exp_m)
    );

    // handshake
    assign in_take  = in_valid && !in_stall;
    assign wr_take  = in_take && !operation;
    assign q_take   = in_take && operation;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (q_take) state_next = ST_SCAN;
            ST_SCAN: if (!scan_go) state_next = ST_RD0;
            ST_RD0:  state_next = ST_RD1;
            ST_RD1:  state_next = ST_RD2;
            ST_RD2:  state_next = ST_RD3;
            ST_RD3:  state_next = ST_RD4;
            ST_RD4:  state_next = ST_MUL0;
            ST_MUL0: state_next = ST_MUL1;
            ST_MUL1: state_next = ST_ROW;
            ST_ROW:  state_next = ST_MZ;
            ST_MZ:   state_next = ST_NUM;
            ST_NUM:  state_next = w_pos ? ST_DIV : ST_SAT;
            ST_DIV:  if (div_done) state_next = ST_SAT;
            ST_SAT:  state_next = ST_EXP;
            ST_EXP:  if (exp_done) state_next = ST_DONE;
            ST_DONE: if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        div_start = (state_reg == ST_NUM) && w_pos;
        exp_start = (state_reg == ST_SAT);
        rd_row_hi = (state_reg == ST_RD2) || (state_reg == ST_RD3);
        rd_col_hi = (state_reg == ST_RD1) || (state_reg == ST_RD3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < BRK_N; i++)
            begin
                brk_reg[i] <= BREAK_RESET[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                brk_reg[cfg_index] <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                cell_reg <= cell_sel;
                ph_reg   <= t5 - {cell_sel, 10'd0};
                z_reg    <= z_cl;
                seg_reg  <= '0;
                blo_reg  <= brk_reg[0];
            end
            ST_SCAN:
            begin
                // advance while the point lies above the next breakpoint
                if (scan_go)
                begin
                    seg_reg <= seg_reg + 3'd1;
                    blo_reg <= brk_next;
                end
                else
                begin
                    bhi_reg <= brk_next;
                end
            end
            ST_RD1:  r0_reg <= rd_data;
            ST_RD2:  r1_reg <= rd_data;
            ST_RD3:  r2_reg <= rd_data;
            ST_RD4:  r3_reg <= rd_data;
            ST_MUL0: pa_reg <= pa_n;
            ST_MUL1: pb_reg <= pb_n;
            ST_ROW:
            begin
                ra_reg <= ra_n;
                rb_reg <= rb_n;
            end
            ST_MZ:   big_reg <= dr * dz;
            ST_NUM:
            begin
                neg_reg  <= num[NUM_W-1];
                rsum_reg <= SUM_W'(ra_reg);
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    rsum_reg <= SUM_W'(ra_reg) + q_signed;
                end
            end
            ST_SAT:
            begin
                rate_reg <= rate_sat;
                sat_reg  <= sat_flag;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    log_rate_reg <= rate_reg;
                    exp_out_reg  <= exp_e;
                    mant_out_reg <= exp_m;
                    sat_out_reg  <= sat_reg;
                end
            end
            default:
            begin
                cell_reg <= cell_reg;
            end
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign log_rate      = log_rate_reg;
    assign rate_exponent = $signed(exp_out_reg);
    assign rate_mantissa = mant_out_reg;
    assign saturated     = sat_out_reg;

endmodule
